### hw/rtl/tscr_pkg.sv
package tscr_pkg;

   localparam int FIELD_BITS = 64;
   localparam int CSR_BITS   = 5;
   localparam int COUNT_BITS = 32;

   localparam logic [CSR_BITS-1:0] CAPACITY_RESET = 5'd16;

   // opcodes
   localparam logic [1:0] OP_PUBLISH = 2'd0;
   localparam logic [1:0] OP_SERVICE = 2'd1;
   localparam logic [1:0] OP_CONSUME = 2'd2;

   // response status codes
   localparam logic [2:0] STATUS_DONE     = 3'd0;
   localparam logic [2:0] STATUS_NOTHING  = 3'd1;
   localparam logic [2:0] STATUS_FULL     = 3'd2;
   localparam logic [2:0] STATUS_BUSY     = 3'd3;
   localparam logic [2:0] STATUS_PROTOCOL = 3'd4;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [FIELD_BITS-1:0] sequence_number;
      logic [FIELD_BITS-1:0] request_word;
      logic                  service_ok;
   } req_word_type;

   typedef struct packed {
      logic [2:0]            status;
      logic                  completed_failed;
      logic [FIELD_BITS-1:0] completed_sequence;
      logic [FIELD_BITS-1:0] completed_request;
      logic [COUNT_BITS-1:0] backpressure_total;
   } rsp_word_type;

endpackage

### hw/rtl/tscr_req_if.sv
interface tscr_req_if;
   logic                     valid;
   logic                     ready;
   tscr_pkg::req_word_type   word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

### hw/rtl/tscr_rsp_if.sv
interface tscr_rsp_if;
   logic                     valid;
   logic                     ready;
   tscr_pkg::rsp_word_type   word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

### hw/rtl/tscr_ram.sv
module tscr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/three_stage_completion_ring.sv
// Completion ring: RING_DEPTH request slots walked by produce, service and
// retire pointers, each wrapping at the configured capacity.
// req_ch carries one word per operation (publish, service, consume); every
// accepted word yields exactly one rsp_ch word with status, the retired
// slot contents on a consume, and the running count of refused publishes.
// csr_write_en/csr_write_data set the capacity (1..RING_DEPTH, reset 16);
// write it only while no operation is in flight.
// Throughput: one operation per cycle unless rsp_ch stalls or the reset
// sweep runs. The response passes the input register, then the result
// register. Slot states live in three copies of a small RAM, one read at
// each pointer's next value, so a pointer's slot state is ready every cycle.
// Reset: pointers and counts clear, then a sweep over every slot empties
// all slot states; req_ch.ready stays low during the sweep.
// When the receiver stalls the result register holds its word, the input
// register fills behind it, and then req_ch.ready drops until rsp_ch moves.
module three_stage_completion_ring #(
   parameter int RING_DEPTH   = 16,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic         clock,
   input  logic         reset,
   tscr_req_if.sink     req_ch,
   tscr_rsp_if.source   rsp_ch,
   input  logic         csr_write_en,
   input  logic [tscr_pkg::CSR_BITS-1:0] csr_write_data
);

   localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W  = ($clog2(RING_DEPTH + 1) > tscr_pkg::CSR_BITS) ?
                           $clog2(RING_DEPTH + 1) : tscr_pkg::CSR_BITS;
   localparam int PAIR_W = 2 * PAYLOAD_BITS;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);

   typedef enum logic [1:0] {
      SLOT_EMPTY,
      SLOT_PENDING,
      SLOT_READY,
      SLOT_ERROR
   } slot_state_type;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] cap);
      logic [CNT_W:0] nxt;
      nxt = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(1);
      return (nxt >= (CNT_W + 1)'(cap)) ? '0 : PTR_W'(nxt);
   endfunction

   logic [tscr_pkg::CSR_BITS-1:0]   capacity_ff;
   logic                            in_valid_ff;
   tscr_pkg::req_word_type          in_word_ff;
   logic                            rsp_valid_ff;
   tscr_pkg::rsp_word_type          rsp_word_ff;
   tscr_pkg::rsp_word_type          rsp_word_in;
   logic [PTR_W-1:0]                prod_ptr_ff, prod_ptr_in;
   logic [PTR_W-1:0]                serv_ptr_ff, serv_ptr_in;
   logic [PTR_W-1:0]                ret_ptr_ff, ret_ptr_in;
   logic [CNT_W-1:0]                wait_serv_ff, wait_serv_in;
   logic [CNT_W-1:0]                wait_ret_ff, wait_ret_in;
   logic [tscr_pkg::COUNT_BITS-1:0] refused_ff, refused_in;
   logic                            clr_active_ff;
   logic [PTR_W-1:0]                clr_idx_ff;
   logic [2:0]                      hit_ff, hit_in;
   slot_state_type                  fwd_state_ff;

   logic                            fire;
   logic                            req_take;
   logic [CNT_W-1:0]                cap_wide, cap_used;
   logic                            st_we;
   logic [PTR_W-1:0]                st_waddr;
   slot_state_type                  st_wval;
   logic [PTR_W-1:0]                st_raddr [3];
   logic [1:0]                      st_q [3];
   slot_state_type                  st_prod, st_serv, st_ret;
   logic                            pay_we;
   logic [PAIR_W-1:0]               pay_wdata, pay_q;

   // slot state copies, one read at each pointer
   for (genvar k = 0; k < 3; k++) begin : g_state
      tscr_ram #(.WIDTH(2), .DEPTH(RING_DEPTH)) u_state_ram (
         .clock   (clock),
         .wr_en   (st_we),
         .wr_addr (st_waddr),
         .wr_data (st_wval),
         .rd_addr (st_raddr[k]),
         .rd_data (st_q[k])
      );
      assign hit_in[k] = st_we && (st_waddr == st_raddr[k]);
   end

   tscr_ram #(.WIDTH(PAIR_W), .DEPTH(RING_DEPTH)) u_payload_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (prod_ptr_ff),
      .wr_data (pay_wdata),
      .rd_addr (ret_ptr_in),
      .rd_data (pay_q)
   );

   assign st_raddr[0] = prod_ptr_in;
   assign st_raddr[1] = serv_ptr_in;
   assign st_raddr[2] = ret_ptr_in;

   assign st_prod = hit_ff[0] ? fwd_state_ff : slot_state_type'(st_q[0]);
   assign st_serv = hit_ff[1] ? fwd_state_ff : slot_state_type'(st_q[1]);
   assign st_ret  = hit_ff[2] ? fwd_state_ff : slot_state_type'(st_q[2]);

   assign pay_wdata = {in_word_ff.sequence_number[PAYLOAD_BITS-1:0],
                       in_word_ff.request_word[PAYLOAD_BITS-1:0]};

   assign cap_wide = CNT_W'(capacity_ff);
   assign cap_used = (cap_wide == '0) ? CNT_W'(1) :
                     ((cap_wide > DEPTH_CNT) ? DEPTH_CNT : cap_wide);

   assign fire     = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !clr_active_ff && (!in_valid_ff || fire);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.word  = rsp_word_ff;

   always_comb begin
      prod_ptr_in  = prod_ptr_ff;
      serv_ptr_in  = serv_ptr_ff;
      ret_ptr_in   = ret_ptr_ff;
      wait_serv_in = wait_serv_ff;
      wait_ret_in  = wait_ret_ff;
      refused_in   = refused_ff;
      st_we        = 1'b0;
      st_waddr     = prod_ptr_ff;
      st_wval      = SLOT_EMPTY;
      pay_we       = 1'b0;
      rsp_word_in  = '0;
      rsp_word_in.status = tscr_pkg::STATUS_PROTOCOL;

      if (clr_active_ff) begin
         st_we    = 1'b1;
         st_waddr = clr_idx_ff;
      end else if (fire) begin
         unique case (in_word_ff.opcode)
            tscr_pkg::OP_PUBLISH: begin
               if ((CNT_W + 1)'(wait_serv_ff) + (CNT_W + 1)'(wait_ret_ff) >=
                   (CNT_W + 1)'(cap_used)) begin
                  refused_in = refused_ff + 1'b1;
                  rsp_word_in.status = tscr_pkg::STATUS_FULL;
               end else if (st_prod != SLOT_EMPTY) begin
                  rsp_word_in.status = tscr_pkg::STATUS_BUSY;
               end else begin
                  st_we        = 1'b1;
                  st_waddr     = prod_ptr_ff;
                  st_wval      = SLOT_PENDING;
                  pay_we       = 1'b1;
                  prod_ptr_in  = advance(prod_ptr_ff, cap_used);
                  wait_serv_in = wait_serv_ff + 1'b1;
                  rsp_word_in.status = tscr_pkg::STATUS_DONE;
               end
            end
            tscr_pkg::OP_SERVICE: begin
               if (wait_serv_ff == '0) begin
                  rsp_word_in.status = tscr_pkg::STATUS_NOTHING;
               end else if (st_serv != SLOT_PENDING) begin
                  rsp_word_in.status = tscr_pkg::STATUS_PROTOCOL;
               end else begin
                  st_we        = 1'b1;
                  st_waddr     = serv_ptr_ff;
                  st_wval      = in_word_ff.service_ok ? SLOT_READY : SLOT_ERROR;
                  serv_ptr_in  = advance(serv_ptr_ff, cap_used);
                  wait_serv_in = wait_serv_ff - 1'b1;
                  wait_ret_in  = wait_ret_ff + 1'b1;
                  rsp_word_in.status = tscr_pkg::STATUS_DONE;
               end
            end
            tscr_pkg::OP_CONSUME: begin
               if (wait_ret_ff == '0) begin
                  rsp_word_in.status = tscr_pkg::STATUS_NOTHING;
               end else if (st_ret != SLOT_READY && st_ret != SLOT_ERROR) begin
                  rsp_word_in.status = tscr_pkg::STATUS_PROTOCOL;
               end else begin
                  st_we       = 1'b1;
                  st_waddr    = ret_ptr_ff;
                  st_wval     = SLOT_EMPTY;
                  ret_ptr_in  = advance(ret_ptr_ff, cap_used);
                  wait_ret_in = wait_ret_ff - 1'b1;
                  rsp_word_in.status           = tscr_pkg::STATUS_DONE;
                  rsp_word_in.completed_failed = (st_ret == SLOT_ERROR);
                  rsp_word_in.completed_sequence =
                     tscr_pkg::FIELD_BITS'(pay_q[PAIR_W-1:PAYLOAD_BITS]);
                  rsp_word_in.completed_request =
                     tscr_pkg::FIELD_BITS'(pay_q[PAYLOAD_BITS-1:0]);
               end
            end
            default: begin
               rsp_word_in.status = tscr_pkg::STATUS_PROTOCOL;
            end
         endcase
      end
      rsp_word_in.backpressure_total = refused_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= tscr_pkg::CAPACITY_RESET;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prod_ptr_ff   <= '0;
         serv_ptr_ff   <= '0;
         ret_ptr_ff    <= '0;
         wait_serv_ff  <= '0;
         wait_ret_ff   <= '0;
         refused_ff    <= '0;
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
         hit_ff        <= '0;
      end else begin
         if (csr_write_en) begin
            capacity_ff <= csr_write_data;
         end
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         prod_ptr_ff  <= prod_ptr_in;
         serv_ptr_ff  <= serv_ptr_in;
         ret_ptr_ff   <= ret_ptr_in;
         wait_serv_ff <= wait_serv_in;
         wait_ret_ff  <= wait_ret_in;
         refused_ff   <= refused_in;
         hit_ff       <= hit_in;
         if (clr_active_ff) begin
            if (clr_idx_ff == LAST_SLOT) begin
               clr_active_ff <= 1'b0;
            end else begin
               clr_idx_ff <= clr_idx_ff + 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_ch.word;
      end
      if (fire) begin
         rsp_word_ff <= rsp_word_in;
      end
      fwd_state_ff <= st_wval;
   end

endmodule
